FILE: design/addressable_rgb_led_chain_driver_unit_macros.svh
// Assertion macros shared by the LED chain driver modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef ADDRESSABLE_RGB_LED_CHAIN_DRIVER_UNIT_MACROS_SVH
`define ADDRESSABLE_RGB_LED_CHAIN_DRIVER_UNIT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define ARCD_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds through reset.
`define ARCD_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: design/arcd_pkg.sv
// Types, constants and helper functions of the LED chain driver.
// Used by the front end, the line engine and the top level; depends on nothing.
package arcd_pkg;

    localparam int MAX_PIXELS  = 1024;
    localparam int ADDR_W      = $clog2(MAX_PIXELS);
    localparam int PIX_CNT_W   = 11;
    localparam int COLOUR_W    = 24;
    localparam int TICK_W      = 16;
    localparam int PHASE_W     = 8;
    localparam int BIT_CNT_W   = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [PIX_CNT_W-1:0] RST_PIXEL_COUNT = '0;
    localparam logic [PHASE_W-1:0]   RST_ONE_HIGH    = 8'd16;
    localparam logic [PHASE_W-1:0]   RST_ONE_LOW     = 8'd9;
    localparam logic [PHASE_W-1:0]   RST_ZERO_HIGH   = 8'd8;
    localparam logic [PHASE_W-1:0]   RST_ZERO_LOW    = 8'd17;
    localparam logic [TICK_W-1:0]    RST_LATCH_GAP   = 16'd1100;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_FILL = 2'd1,
        OP_SHOW = 2'd2,
        OP_TICK = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_BUSY  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_COUNT = 3'd0,
        CFG_ONE_HIGH    = 3'd1,
        CFG_ONE_LOW     = 3'd2,
        CFG_ZERO_HIGH   = 3'd3,
        CFG_ZERO_LOW    = 3'd4,
        CFG_LATCH_GAP   = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2,
        PH_GAP  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_RUN,
        BK_FILL,
        BK_LOAD
    } t_back_state;

    typedef struct packed {
        logic [PIX_CNT_W-1:0] pixel_count;
        logic [PHASE_W-1:0]   one_high;
        logic [PHASE_W-1:0]   one_low;
        logic [PHASE_W-1:0]   zero_high;
        logic [PHASE_W-1:0]   zero_low;
        logic [TICK_W-1:0]    latch_gap;
    } t_cfg;

    // Colour is stored green, red, blue from the top down.
    typedef struct packed {
        t_op                 op;
        logic                in_range;
        logic [ADDR_W-1:0]   index;
        logic [COLOUR_W-1:0] colour;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    function automatic logic [PIX_CNT_W-1:0] f_eff_count(input logic [PIX_CNT_W-1:0] cnt);
        logic [PIX_CNT_W-1:0] lim;
        lim = PIX_CNT_W'(MAX_PIXELS);
        return (cnt > lim) ? lim : cnt;
    endfunction

    function automatic logic [TICK_W-1:0] f_at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

FILE: design/arcd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module arcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/arcd_queue.sv
// Short FIFO between the command front end and the line engine.
// Depends on nothing beyond its parameters.
module arcd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: design/arcd_front.sv
// Command front end: takes commands, decodes them and checks set indexes.
// Depends on arcd_pkg.
module arcd_front
    import arcd_pkg::*;
(
    input  logic                 i_start,
    input  logic [1:0]           i_command,
    input  logic [ADDR_W-1:0]    i_pixel_index,
    input  logic [PHASE_W-1:0]   i_red,
    input  logic [PHASE_W-1:0]   i_green,
    input  logic [PHASE_W-1:0]   i_blue,
    input  logic [PIX_CNT_W-1:0] i_eff_count,
    input  logic                 i_queue_full,
    input  logic                 i_clearing,
    output logic                 o_busy,
    output logic                 o_push,
    output t_item                o_item
);

    // Hold off new transactions while the store is swept or the queue is full.
    assign o_busy = i_clearing || i_queue_full;
    assign o_push = i_start && !o_busy;

    always_comb begin
        o_item.op       = t_op'(i_command);
        o_item.index    = i_pixel_index;
        o_item.colour   = {i_green, i_red, i_blue};
        o_item.in_range = ({1'b0, i_pixel_index} < i_eff_count);
    end

endmodule

FILE: design/arcd_back.sv
// Line engine: executes queued commands, owns the pixel store and the bit timing.
// Depends on arcd_pkg, arcd_ram and the assertion macro header.
`include "addressable_rgb_led_chain_driver_unit_macros.svh"

module arcd_back
    import arcd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic [PIX_CNT_W-1:0] i_eff_count,
    input  logic                 i_q_valid,
    input  t_item                i_q_item,
    output logic                 o_q_pop,
    output logic                 o_clearing,
    output logic                 o_res_valid,
    output logic                 o_line_level,
    output logic [1:0]           o_status,
    output logic                 o_busy_res
);

    t_back_state          r_state, n_state;
    t_phase               r_phase, n_phase;
    logic                 r_sending, n_sending;
    logic [PIX_CNT_W-1:0] r_ptr, n_ptr;
    logic [BIT_CNT_W-1:0] r_bit, n_bit;
    logic [TICK_W-1:0]    r_ticks, n_ticks;
    logic [COLOUR_W-1:0]  r_shift, n_shift;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [ADDR_W-1:0]    r_fill_last, n_fill_last;
    logic [COLOUR_W-1:0]  r_fill_colour, n_fill_colour;
    logic                 r_res_valid, n_res_valid;
    logic                 r_res_line, n_res_line;
    t_status              r_res_status, n_res_status;
    logic                 r_res_busy, n_res_busy;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [COLOUR_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [COLOUR_W-1:0]  ram_rdata;

    arcd_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        logic [PIX_CNT_W-1:0] next_ptr;
        next_ptr      = r_ptr + PIX_CNT_W'(1);
        n_state       = r_state;
        n_phase       = r_phase;
        n_sending     = r_sending;
        n_ptr         = r_ptr;
        n_bit         = r_bit;
        n_ticks       = r_ticks;
        n_shift       = r_shift;
        n_addr        = r_addr;
        n_fill_last   = r_fill_last;
        n_fill_colour = r_fill_colour;
        n_res_valid   = 1'b0;
        n_res_status  = ST_OK;
        o_q_pop       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_addr;
        ram_wdata     = '0;
        ram_raddr     = r_ptr[ADDR_W-1:0];

        unique case (r_state)
            BK_CLEAR: begin
                ram_we = 1'b1;
                n_addr = r_addr + ADDR_W'(1);
                if (r_addr == ADDR_W'(MAX_PIXELS - 1)) begin
                    n_state = BK_RUN;
                end
            end
            BK_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = r_fill_colour;
                n_addr    = r_addr + ADDR_W'(1);
                if (r_addr == r_fill_last) begin
                    n_state = BK_RUN;
                end
            end
            BK_LOAD: begin
                // Store data for the pixel addressed last cycle is now out.
                n_shift = ram_rdata;
                n_bit   = BIT_CNT_W'(COLOUR_W - 1);
                n_ticks = f_at_least_one({8'd0, ram_rdata[COLOUR_W-1] ? i_cfg.one_high
                                                                      : i_cfg.zero_high});
                n_state = BK_RUN;
            end
            BK_RUN: begin
                if (i_q_valid) begin
                    o_q_pop     = 1'b1;
                    n_res_valid = 1'b1;
                    unique case (i_q_item.op)
                        OP_TICK: begin
                            if (r_sending) begin
                                if (r_ticks > TICK_W'(1)) begin
                                    n_ticks = r_ticks - TICK_W'(1);
                                end else begin
                                    unique case (r_phase)
                                        PH_HIGH: begin
                                            n_phase = PH_LOW;
                                            n_ticks = f_at_least_one({8'd0,
                                                r_shift[COLOUR_W-1] ? i_cfg.one_low
                                                                    : i_cfg.zero_low});
                                        end
                                        PH_LOW: begin
                                            if (r_bit != '0) begin
                                                n_bit   = r_bit - BIT_CNT_W'(1);
                                                n_shift = r_shift << 1;
                                                n_phase = PH_HIGH;
                                                n_ticks = f_at_least_one({8'd0,
                                                    r_shift[COLOUR_W-2] ? i_cfg.one_high
                                                                        : i_cfg.zero_high});
                                            end else begin
                                                n_ptr     = next_ptr;
                                                ram_raddr = next_ptr[ADDR_W-1:0];
                                                if (next_ptr < i_eff_count) begin
                                                    n_phase = PH_HIGH;
                                                    n_state = BK_LOAD;
                                                end else begin
                                                    n_phase = PH_GAP;
                                                    n_ticks = f_at_least_one(i_cfg.latch_gap);
                                                end
                                            end
                                        end
                                        PH_GAP: begin
                                            n_phase   = PH_IDLE;
                                            n_ticks   = '0;
                                            n_sending = 1'b0;
                                        end
                                        default: begin
                                            n_phase   = PH_IDLE;
                                            n_sending = 1'b0;
                                        end
                                    endcase
                                end
                            end
                        end
                        OP_SET: begin
                            if (r_sending) begin
                                n_res_status = ST_BUSY;
                            end else if (!i_q_item.in_range) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = i_q_item.index;
                                ram_wdata = i_q_item.colour;
                            end
                        end
                        OP_FILL: begin
                            if (r_sending) begin
                                n_res_status = ST_BUSY;
                            end else if (i_eff_count != '0) begin
                                n_state       = BK_FILL;
                                n_addr        = '0;
                                n_fill_colour = i_q_item.colour;
                                n_fill_last   = ADDR_W'(i_eff_count - PIX_CNT_W'(1));
                            end
                        end
                        OP_SHOW: begin
                            if (r_sending) begin
                                n_res_status = ST_BUSY;
                            end else begin
                                n_sending = 1'b1;
                                n_ptr     = '0;
                                ram_raddr = '0;
                                if (i_eff_count != '0) begin
                                    n_phase = PH_HIGH;
                                    n_state = BK_LOAD;
                                end else begin
                                    n_phase = PH_GAP;
                                    n_ticks = f_at_least_one(i_cfg.latch_gap);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: n_state = BK_RUN;
        endcase

        n_res_line = n_sending && (n_phase == PH_HIGH);
        n_res_busy = n_sending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_phase     <= PH_IDLE;
            r_sending   <= 1'b0;
            r_ptr       <= '0;
            r_bit       <= '0;
            r_ticks     <= '0;
            r_shift     <= '0;
            r_addr      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_sending   <= n_sending;
            r_ptr       <= n_ptr;
            r_bit       <= n_bit;
            r_ticks     <= n_ticks;
            r_shift     <= n_shift;
            r_addr      <= n_addr;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_last   <= n_fill_last;
        r_fill_colour <= n_fill_colour;
        r_res_line    <= n_res_line;
        r_res_status  <= n_res_status;
        r_res_busy    <= n_res_busy;
    end

    assign o_clearing   = (r_state == BK_CLEAR);
    assign o_res_valid  = r_res_valid;
    assign o_line_level = r_res_line;
    assign o_status     = r_res_status;
    assign o_busy_res   = r_res_busy;

    `ARCD_ASSERT(a_sending_matches_phase, i_clk, i_rst_n, r_sending == (r_phase != PH_IDLE), "sending flag and line phase disagree")
    `ARCD_ASSERT(a_no_store_write_in_frame, i_clk, i_rst_n, ram_we |-> !r_sending, "pixel store written during a frame")
    `ARCD_ASSERT(a_ticks_live_in_frame, i_clk, i_rst_n, (r_state == BK_RUN && r_sending) |-> (r_ticks != '0), "running phase has no ticks left")
    `ARCD_ASSERT(a_load_follows_run, i_clk, i_rst_n, (r_state == BK_LOAD) |-> ($past(r_state) == BK_RUN && r_phase == PH_HIGH), "pixel load not entered from a tick or show")

endmodule

FILE: design/addressable_rgb_led_chain_driver_unit.sv
// Top level of the addressable RGB LED chain driver: configuration registers,
// front end, command queue and line engine. Depends on arcd_pkg and all arcd_ modules.
//
// After reset the pixel store is swept to black, one pixel per cycle. o_busy
// stays high during that sweep and no command is taken, but configuration
// writes are. A command is taken when i_start is high and o_busy is low. It
// lands in a short queue (Q_DEPTH entries, two by default), so the front end
// keeps taking commands while the line engine works. A tick or show that
// moves to a new pixel passes through a load state for the registered read
// of the pixel store. A fill writes one pixel per cycle. Every command
// produces exactly one result, shown for a single cycle with o_result_valid
// high. The engine registers the result when it takes the command from the
// queue, so a result passes through the queue and then the result
// register. There is no back-pressure on results. Configuration is accepted
// every cycle and should only be written while no command is pending.
module addressable_rgb_led_chain_driver_unit
    import arcd_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [1:0]            i_command,
    input  logic [ADDR_W-1:0]     i_pixel_index,
    input  logic [PHASE_W-1:0]    i_red,
    input  logic [PHASE_W-1:0]    i_green,
    input  logic [PHASE_W-1:0]    i_blue,
    output logic                  o_result_valid,
    output logic                  o_line_level,
    output logic [1:0]            o_status,
    output logic                  o_busy_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                 r_cfg, n_cfg;
    logic [PIX_CNT_W-1:0] eff_count;
    logic                 q_push, q_pop, q_valid, q_full, clearing;
    t_item                push_item;
    logic [ITEM_W-1:0]    q_data;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PIXEL_COUNT: n_cfg.pixel_count = i_cfg_data[PIX_CNT_W-1:0];
                CFG_ONE_HIGH:    n_cfg.one_high    = i_cfg_data[PHASE_W-1:0];
                CFG_ONE_LOW:     n_cfg.one_low     = i_cfg_data[PHASE_W-1:0];
                CFG_ZERO_HIGH:   n_cfg.zero_high   = i_cfg_data[PHASE_W-1:0];
                CFG_ZERO_LOW:    n_cfg.zero_low    = i_cfg_data[PHASE_W-1:0];
                CFG_LATCH_GAP:   n_cfg.latch_gap   = i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_count <= RST_PIXEL_COUNT;
            r_cfg.one_high    <= RST_ONE_HIGH;
            r_cfg.one_low     <= RST_ONE_LOW;
            r_cfg.zero_high   <= RST_ZERO_HIGH;
            r_cfg.zero_low    <= RST_ZERO_LOW;
            r_cfg.latch_gap   <= RST_LATCH_GAP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign eff_count = f_eff_count(r_cfg.pixel_count);

    arcd_front u_front (
        .i_start       (i_start),
        .i_command     (i_command),
        .i_pixel_index (i_pixel_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_eff_count   (eff_count),
        .i_queue_full  (q_full),
        .i_clearing    (clearing),
        .o_busy        (o_busy),
        .o_push        (q_push),
        .o_item        (push_item)
    );

    arcd_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_item),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    arcd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_eff_count  (eff_count),
        .i_q_valid    (q_valid),
        .i_q_item     (t_item'(q_data)),
        .o_q_pop      (q_pop),
        .o_clearing   (clearing),
        .o_res_valid  (o_result_valid),
        .o_line_level (o_line_level),
        .o_status     (o_status),
        .o_busy_res   (o_busy_res)
    );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the addressable RGB LED chain driver.
// Drives commands and register writes, predicts every result with its own
// model of the pixel store and line timing; depends on arcd_pkg and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import arcd_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic    line;
        t_status status;
        logic    busy;
    } t_line_result;

    // Scoreboard: keeps its own copy of the store, the registers and the frame
    // position, and queues the result each accepted command must produce.
    class led_chain_scoreboard;
        bit [COLOUR_W-1:0]  colours [MAX_PIXELS];
        bit [PIX_CNT_W-1:0] pixel_count;
        bit [PHASE_W-1:0]   one_high, one_low, zero_high, zero_low;
        bit [TICK_W-1:0]    latch_gap;
        bit                 sending;
        bit [PIX_CNT_W-1:0] pixel_ptr;
        bit [BIT_CNT_W-1:0] bit_ptr;
        t_phase             phase;
        bit [TICK_W-1:0]    ticks_left;
        bit [COLOUR_W-1:0]  shift_word;
        t_line_result       pending_line_results[$];
        int                 mismatches;

        function new();
            foreach (colours[i]) colours[i] = '0;
            pixel_count = RST_PIXEL_COUNT;
            one_high    = RST_ONE_HIGH;
            one_low     = RST_ONE_LOW;
            zero_high   = RST_ZERO_HIGH;
            zero_low    = RST_ZERO_LOW;
            latch_gap   = RST_LATCH_GAP;
            sending     = 1'b0;
            pixel_ptr   = '0;
            bit_ptr     = '0;
            phase       = PH_IDLE;
            ticks_left  = '0;
            shift_word  = '0;
            mismatches  = 0;
        endfunction

        function bit [PIX_CNT_W-1:0] used_pixels();
            return (pixel_count > MAX_PIXELS) ? PIX_CNT_W'(MAX_PIXELS) : pixel_count;
        endfunction

        // A zero length register behaves as one tick.
        function bit [TICK_W-1:0] ticks_of(bit [TICK_W-1:0] v);
            return (v == '0) ? TICK_W'(1) : v;
        endfunction

        function void load_bit_high();
            phase      = PH_HIGH;
            ticks_left = ticks_of(TICK_W'(shift_word[bit_ptr] ? one_high : zero_high));
        endfunction

        function void load_pixel_or_latch();
            if (pixel_ptr < used_pixels()) begin
                shift_word = colours[pixel_ptr];
                bit_ptr    = 5'd23;
                load_bit_high();
            end else begin
                phase      = PH_GAP;
                ticks_left = ticks_of(latch_gap);
            end
        endfunction

        function void finish_phase();
            case (phase)
                PH_HIGH: begin
                    phase      = PH_LOW;
                    ticks_left = ticks_of(TICK_W'(shift_word[bit_ptr] ? one_low : zero_low));
                end
                PH_LOW: begin
                    if (bit_ptr > 0) begin
                        bit_ptr--;
                        load_bit_high();
                    end else begin
                        pixel_ptr++;
                        load_pixel_or_latch();
                    end
                end
                default: begin
                    phase      = PH_IDLE;
                    ticks_left = '0;
                    sending    = 1'b0;
                end
            endcase
        endfunction

        function void write_register(t_cfg_reg r, bit [CFG_DATA_W-1:0] d);
            case (r)
                CFG_PIXEL_COUNT: pixel_count = d[PIX_CNT_W-1:0];
                CFG_ONE_HIGH:    one_high    = d[PHASE_W-1:0];
                CFG_ONE_LOW:     one_low     = d[PHASE_W-1:0];
                CFG_ZERO_HIGH:   zero_high   = d[PHASE_W-1:0];
                CFG_ZERO_LOW:    zero_low    = d[PHASE_W-1:0];
                CFG_LATCH_GAP:   latch_gap   = d;
                default: ;
            endcase
        endfunction

        function void note_command(t_op op, bit [ADDR_W-1:0] idx,
                                   bit [7:0] r, bit [7:0] g, bit [7:0] b);
            bit [COLOUR_W-1:0] colour;
            t_status           st;
            t_line_result      res;
            int                i;
            colour = {g, r, b};
            st     = ST_OK;
            if (op == OP_TICK) begin
                if (sending) begin
                    if (ticks_left > 0) ticks_left--;
                    if (ticks_left == 0) finish_phase();
                end
            end else if (sending) begin
                st = ST_BUSY;
            end else if (op == OP_SET) begin
                if (idx >= used_pixels()) st = ST_RANGE;
                else colours[idx] = colour;
            end else if (op == OP_FILL) begin
                for (i = 0; i < used_pixels(); i++) colours[i] = colour;
            end else begin
                sending   = 1'b1;
                pixel_ptr = '0;
                load_pixel_or_latch();
            end
            res.line   = sending && (phase == PH_HIGH);
            res.status = st;
            res.busy   = sending;
            pending_line_results.push_back(res);
        endfunction

        function void check_result(logic line, logic [1:0] status, logic busy);
            t_line_result want;
            if (pending_line_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: line %b status %0d busy %b",
                             line, status, busy);
                return;
            end
            want = pending_line_results.pop_front();
            if (line !== want.line || status !== want.status || busy !== want.busy) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: expected line %b status %0d busy %b,",
                             want.line, want.status, want.busy);
                    $display("                 got line %b status %0d busy %b",
                             line, status, busy);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic [1:0]            i_command;
    logic [ADDR_W-1:0]     i_pixel_index;
    logic [PHASE_W-1:0]    i_red;
    logic [PHASE_W-1:0]    i_green;
    logic [PHASE_W-1:0]    i_blue;
    logic                  o_result_valid;
    logic                  o_line_level;
    logic [1:0]            o_status;
    logic                  o_busy_res;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    led_chain_scoreboard sb;
    int idle_pct = 31;
    int items_sent = 0;
    int cycle_count = 0;

    addressable_rgb_led_chain_driver_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_command      (i_command),
        .i_pixel_index  (i_pixel_index),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .o_result_valid (o_result_valid),
        .o_line_level   (o_line_level),
        .o_status       (o_status),
        .o_busy_res     (o_busy_res),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Results cannot be held off: sample mid-cycle, well clear of the edges.
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid !== 1'b0)
            sb.check_result(o_line_level, o_status, o_busy_res);
    end

    task automatic send_command(t_op op, logic [ADDR_W-1:0] idx,
                                logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic taken;
        while ($urandom_range(99) < idle_pct) begin
            i_start       <= 1'b0;
            i_command     <= 2'($urandom);
            i_pixel_index <= ADDR_W'($urandom);
            @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_command     <= op;
        i_pixel_index <= idx;
        i_red         <= r;
        i_green       <= g;
        i_blue        <= b;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = (o_busy === 1'b0);
            @(posedge i_clk);
        end
        sb.note_command(op, idx, r, g, b);
        items_sent++;
    endtask

    // Leaves valid high so that back-to-back writes need not drop it in between.
    task automatic write_reg(t_cfg_reg r, logic [CFG_DATA_W-1:0] d);
        logic taken;
        while ($urandom_range(99) < idle_pct) begin
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= d;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = (o_cfg_ready === 1'b1);
            @(posedge i_clk);
        end
        sb.write_register(r, d);
    endtask

    task automatic end_config();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop start and wait until every queued command has answered.
    task automatic drain_results();
        i_start <= 1'b0;
        while (sb.pending_line_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Tick the frame along, with the odd command thrown in to be rejected.
    task automatic run_frame(int cap);
        int n;
        n = 0;
        while (sb.sending && n < cap) begin
            if ($urandom_range(99) < 6)
                send_command(t_op'($urandom_range(0, 2)), ADDR_W'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom));
            else
                send_command(OP_TICK, ADDR_W'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom));
            n++;
        end
    endtask

    task automatic random_phase();
        int pick, val, k, n_prep, used;
        drain_results();
        if ($urandom_range(99) < 60) begin
            pick = $urandom_range(99);
            if (pick < 50)      val = $urandom_range(0, 1);
            else if (pick < 80) val = $urandom_range(2, 3);
            else if (pick < 92) val = $urandom_range(4, 8);
            else                val = $urandom_range(9, 2047);
            write_reg(CFG_PIXEL_COUNT, {5'($urandom), 11'(val)});
        end
        for (k = CFG_ONE_HIGH; k <= CFG_ZERO_LOW; k++) begin
            if ($urandom_range(99) < 50) begin
                val = ($urandom_range(99) < 85) ? $urandom_range(0, 2) : $urandom_range(0, 255);
                write_reg(t_cfg_reg'(k), {8'($urandom), 8'(val)});
            end
        end
        if ($urandom_range(99) < 50) begin
            val = ($urandom_range(99) < 90) ? $urandom_range(0, 30) : $urandom_range(0, 400);
            write_reg(CFG_LATCH_GAP, 16'(val));
        end
        end_config();

        if (!sb.sending) begin
            n_prep = $urandom_range(0, 5);
            repeat (n_prep) begin
                pick = $urandom_range(99);
                used = int'(sb.used_pixels());
                if (pick < 60) begin
                    val = ($urandom_range(99) < 80 && used > 0) ?
                          $urandom_range(0, used - 1) : $urandom_range(0, 1023);
                    send_command(OP_SET, ADDR_W'(val),
                                 8'($urandom), 8'($urandom), 8'($urandom));
                end else if (pick < 85) begin
                    send_command(OP_FILL, ADDR_W'($urandom),
                                 8'($urandom), 8'($urandom), 8'($urandom));
                end else begin
                    send_command(t_op'($urandom_range(0, 3)), ADDR_W'($urandom),
                                 8'($urandom), 8'($urandom), 8'($urandom));
                end
            end
            if ($urandom_range(99) < 90)
                send_command(OP_SHOW, ADDR_W'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom));
        end
        // Now and then stop early so the next settings land mid-frame.
        run_frame(($urandom_range(99) < 70) ? 400 : $urandom_range(5, 120));
    endtask

    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_command     <= OP_TICK;
        i_pixel_index <= '0;
        i_red         <= '0;
        i_green       <= '0;
        i_blue        <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_PIXEL_COUNT;
        i_cfg_data    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: empty chain, so every set is out of range.
        send_command(OP_SET, 10'd1023, 8'hff, 8'hff, 8'hff);
        send_command(OP_TICK, 10'd0, 8'h00, 8'h00, 8'h00);
        send_command(OP_FILL, 10'd0, 8'h12, 8'h34, 8'h56);

        // Empty chain show: latch gap only, zero length acting as one tick.
        drain_results();
        write_reg(CFG_LATCH_GAP, 16'd0);
        end_config();
        send_command(OP_SHOW, 10'd0, 8'h00, 8'h00, 8'h00);
        send_command(OP_SET, 10'd0, 8'h01, 8'h02, 8'h03);
        send_command(OP_TICK, 10'd0, 8'h00, 8'h00, 8'h00);
        send_command(OP_TICK, 10'd0, 8'h00, 8'h00, 8'h00);

        // Count above the store size clamps to the full store.
        drain_results();
        write_reg(CFG_PIXEL_COUNT, 16'hffff);
        end_config();
        send_command(OP_SET, 10'd1023, 8'hff, 8'hff, 8'hff);
        send_command(OP_SET, 10'd0, 8'h00, 8'h00, 8'h00);
        send_command(OP_FILL, 10'd0, 8'ha5, 8'h5a, 8'h3c);

        // Short frame with zero and minimum phase lengths, busy rejections.
        drain_results();
        write_reg(CFG_PIXEL_COUNT, 16'd2);
        write_reg(CFG_ONE_HIGH, 16'd0);
        write_reg(CFG_ONE_LOW, 16'd1);
        write_reg(CFG_ZERO_HIGH, 16'd1);
        write_reg(CFG_ZERO_LOW, 16'd0);
        write_reg(CFG_LATCH_GAP, 16'd2);
        end_config();
        send_command(OP_SET, 10'd1, 8'h00, 8'hff, 8'ha5);
        send_command(OP_SET, 10'd2, 8'hff, 8'hff, 8'hff);
        send_command(OP_SHOW, 10'd0, 8'h00, 8'h00, 8'h00);
        send_command(OP_SET, 10'd0, 8'hff, 8'hff, 8'hff);
        send_command(OP_FILL, 10'd0, 8'hff, 8'hff, 8'hff);
        send_command(OP_SHOW, 10'd0, 8'h00, 8'h00, 8'h00);
        run_frame(1000);

        while (items_sent < 200) random_phase();

        // Close any frame left running: shrink the chain so it ends soon.
        drain_results();
        write_reg(CFG_PIXEL_COUNT, 16'd0);
        write_reg(CFG_ONE_HIGH, 16'd0);
        write_reg(CFG_ONE_LOW, 16'd0);
        write_reg(CFG_ZERO_HIGH, 16'd0);
        write_reg(CFG_ZERO_LOW, 16'd0);
        write_reg(CFG_LATCH_GAP, 16'd1);
        end_config();
        run_frame(200000);

        // Full store frame, cut short by lowering the count mid-frame.
        drain_results();
        write_reg(CFG_PIXEL_COUNT, 16'd1024);
        end_config();
        send_command(OP_FILL, 10'd0, 8'($urandom), 8'($urandom), 8'($urandom));
        send_command(OP_SET, 10'd1023, 8'($urandom), 8'($urandom), 8'($urandom));
        send_command(OP_SET, 10'd2, 8'($urandom), 8'($urandom), 8'($urandom));
        send_command(OP_SHOW, 10'd0, 8'h00, 8'h00, 8'h00);
        run_frame(60);
        drain_results();
        write_reg(CFG_PIXEL_COUNT, 16'd2);
        end_config();
        run_frame(200000);

        // Longest high phase on the first bit, sent without any idle cycles.
        drain_results();
        idle_pct = 0;
        write_reg(CFG_PIXEL_COUNT, 16'd1);
        write_reg(CFG_ONE_HIGH, 16'd255);
        write_reg(CFG_ONE_LOW, 16'd1);
        write_reg(CFG_ZERO_HIGH, 16'd1);
        write_reg(CFG_ZERO_LOW, 16'd1);
        write_reg(CFG_LATCH_GAP, 16'd3);
        end_config();
        send_command(OP_SET, 10'd0, 8'h00, 8'h80, 8'h00);
        send_command(OP_SHOW, 10'd0, 8'h00, 8'h00, 8'h00);
        run_frame(200000);
        idle_pct = 31;

        // Longest latch gap: only its start is exercised.
        drain_results();
        write_reg(CFG_PIXEL_COUNT, 16'd0);
        write_reg(CFG_LATCH_GAP, 16'hffff);
        end_config();
        send_command(OP_SHOW, 10'd0, 8'h00, 8'h00, 8'h00);
        run_frame(40);

        drain_results();
        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_line_results.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
